>>> src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Default line store depth; the line holds one character less
    localparam int LINE_DEPTH_DEFAULT = 32;

    // Character codes
    localparam logic [7:0] CH_ENTER = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BELL  = 8'h07;

    // Result kinds
    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_BELL   = 3'd1;
    localparam logic [2:0] KIND_EOL    = 3'd2;
    localparam logic [2:0] KIND_PROMPT = 3'd3;
    localparam logic [2:0] KIND_CMD    = 3'd4;

    // One result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       command_last;
        logic       last;
    } sle_result_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO,
        ST_BELL,
        ST_BS1,
        ST_SPACE,
        ST_BS2,
        ST_EOL_A,
        ST_CMD,
        ST_EOL_B,
        ST_PROMPT
    } sle_state_t;

endpackage

>>> src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Line store memory and the sequencer that decodes received bytes and
// produces the result items, reading stored commands back on Enter.
// ----------------------------------------------------------------------------
module sle_ctrl
    import sle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // incoming item
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        rx_fault,
    // configuration
    input  logic        cfg_valid,
    input  logic        cfg_data,
    // result push toward the output register
    output logic        push_valid,
    input  logic        push_ready,
    output sle_result_t push_data
);

    localparam int LEN_W = $clog2(LINE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);

    sle_state_t state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    logic             cmd_en_reg;

    logic             accept;
    logic             fire;
    logic             is_enter;
    logic             is_erase;
    logic             is_ctrl;
    logic             cmd_last;

    // line store, synchronous read
    logic [7:0]       mem [LINE_DEPTH];
    logic             wr_en;
    logic             rd_en;
    logic [LEN_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    assign accept   = in_valid && in_ready;
    assign fire     = push_valid && push_ready;
    assign is_enter = (rx_byte == CH_ENTER);
    assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign is_ctrl  = (rx_byte < CH_SPACE) || (len_reg == LEN_MAX);
    assign cmd_last = ((idx_reg + 1'b1) == len_reg);
    assign wr_en    = accept && !rx_fault && !is_enter && !is_erase && !is_ctrl;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // command output enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            cmd_en_reg <= cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    // latched input byte
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !rx_fault)
                begin
                    byte_next = rx_byte;
                    if (is_enter)
                    begin
                        state_next = (len_reg != '0) ? ST_EOL_A : ST_EOL_B;
                    end
                    else if (is_erase)
                    begin
                        if (len_reg != '0)
                        begin
                            len_next   = len_reg - 1'b1;
                            state_next = ST_BS1;
                        end
                    end
                    else if (is_ctrl)
                    begin
                        state_next = ST_BELL;
                    end
                    else
                    begin
                        len_next   = len_reg + 1'b1;
                        state_next = ST_ECHO;
                    end
                end
            end
            ST_ECHO, ST_BELL, ST_BS2:
            begin
                if (fire) state_next = ST_IDLE;
            end
            ST_BS1:
            begin
                if (fire) state_next = ST_SPACE;
            end
            ST_SPACE:
            begin
                if (fire) state_next = ST_BS2;
            end
            ST_EOL_A:
            begin
                if (fire)
                begin
                    idx_next   = '0;
                    state_next = cmd_en_reg ? ST_CMD : ST_EOL_B;
                end
            end
            ST_CMD:
            begin
                if (fire)
                begin
                    if (cmd_last)
                    begin
                        state_next = ST_EOL_B;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_EOL_B:
            begin
                if (fire) state_next = ST_PROMPT;
            end
            ST_PROMPT:
            begin
                if (fire)
                begin
                    len_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs per state
    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, out_byte: 8'h00, command_last: 1'b0, last: 1'b0};
        rd_en      = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                push_valid = 1'b0;
            end
            ST_ECHO:
            begin
                push_data.out_byte = byte_reg;
                push_data.last     = 1'b1;
            end
            ST_BELL:
            begin
                push_data.kind     = KIND_BELL;
                push_data.out_byte = CH_BELL;
                push_data.last     = 1'b1;
            end
            ST_BS1:
            begin
                push_data.out_byte = CH_BS;
            end
            ST_SPACE:
            begin
                push_data.out_byte = CH_SPACE;
            end
            ST_BS2:
            begin
                push_data.out_byte = CH_BS;
                push_data.last     = 1'b1;
            end
            ST_EOL_A:
            begin
                push_data.kind = KIND_EOL;
                // fetch the first command byte as the marker leaves
                rd_en   = fire && cmd_en_reg;
                rd_addr = '0;
            end
            ST_CMD:
            begin
                push_data.kind         = KIND_CMD;
                push_data.out_byte     = rd_data;
                push_data.command_last = cmd_last;
                rd_en   = fire && !cmd_last;
                rd_addr = idx_reg + 1'b1;
            end
            ST_EOL_B:
            begin
                push_data.kind = KIND_EOL;
            end
            ST_PROMPT:
            begin
                push_data.kind = KIND_PROMPT;
                push_data.last = 1'b1;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

endmodule

>>> src/sle_out_reg.sv
// ----------------------------------------------------------------------------
// sle_out_reg
// Output register stage between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module sle_out_reg
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  sle_result_t push_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output sle_result_t m_data
);

    logic        valid_reg;
    sle_result_t data_reg;

    // stage takes a new result when empty or when its result leaves
    assign push_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_data     = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

endmodule

>>> src/serial_line_editor_top.sv
// ----------------------------------------------------------------------------
// serial_line_editor_top
// Command line editor for a serial console receive stream.
// ----------------------------------------------------------------------------
// One received byte is taken per transaction when the editor is idle. A
// printable byte or a bell is accepted and then issues its one result; an
// erase issues 3 results (none on an empty line); Enter issues 2 results on
// an empty line and 3 + L results otherwise (L = stored characters, or 0 when
// command output is off) at one per cycle as long as the result stream does
// not stall, and the next byte is taken once the last result has been issued.
// The sequencer walks the line store one address per result, through its
// registered read port. Results pass through one output register, so a byte
// can be accepted while the final result of the previous one still waits.
// ----------------------------------------------------------------------------
module serial_line_editor_top
    import sle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    // received bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] rx_fault
    // results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [2:0] kind, [3] command_last
    output logic       m_tlast,   // last result of the received byte
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // command_output_enable
);

    logic        push_valid;
    logic        push_ready;
    sle_result_t push_data;
    sle_result_t m_data;

    assign cfg_ready = 1'b1;

    sle_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .rx_byte    (s_tdata),
        .rx_fault   (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sle_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data     (m_data)
    );

    // pack result fields onto the stream
    assign m_tdata = m_data.out_byte;
    assign m_tuser = {m_data.command_last, m_data.kind};
    assign m_tlast = m_data.last;

endmodule

>>> src/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the serial line editor result stream.
// ----------------------------------------------------------------------------
module sle_checker
    import sle_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // prompt always closes the reply to a byte
    a_prompt_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == KIND_PROMPT) |-> m_tlast && (m_tdata == 8'h00))
        else $error("prompt not final or carries data");

    // command end flag only on command bytes, and never the final result
    a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == KIND_CMD) && !m_tlast)
        else $error("command end flag misplaced");

    // bell is a lone 0x07
    a_bell: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == KIND_BELL) |-> (m_tdata == CH_BELL) && m_tlast)
        else $error("bell result malformed");

endmodule

bind serial_line_editor_top sle_checker u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
